// ===== sv/tcw_pkg.sv =====
package tcw_pkg;

    localparam int CELL_W = 16;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam int         TAB_STOP   = 8;

    typedef enum logic [2:0] {
        OP_READ,
        OP_CR,
        OP_LF,
        OP_TAB,
        OP_PRINT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] code;
        logic [4:0] row;
        logic [6:0] col;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_PUT,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } t_bstate;

endpackage

// ===== sv/text_console_writer_unit.sv =====
// Text-mode console writer with a ROWS x COLS screen of 16-bit cells.
// Input queue side: drive the item on i_action, i_char_code, i_read_row and
// i_read_col with push high; the beat is taken when full is low. A put item
// (action 0) handles CR, LF, tab and printable codes; a read item returns one
// stored cell for scan-out. Result queue side: while empty is low the oldest
// result is on o_cell_data, o_cursor_col, o_cursor_row and o_scrolled, and it
// is taken by a pop beat. i_attr_we loads i_attribute as the colour byte.
// A two-entry command queue sits in front of the executing sequencer, and one
// result register follows it, so beats are taken while a result waits.
// The screen memory moves one cell a cycle: a read fetches one cell, a printable
// writes one, CR blanks the cursor row, a tab writes spaces up to the next tab
// stop, and a scroll copies each row up by one and blanks the last row.
// After reset every screen cell is cleared to a blank cell while full is held
// high; the cursor starts at row 0, column 0 and the attribute at 7. When the
// receiver stalls, the sequencer waits with its result and the command queue
// fills, after which full rises.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_action,
    input  logic [7:0]  i_char_code,
    input  logic [4:0]  i_read_row,
    input  logic [6:0]  i_read_col,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_cell_data,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic        o_scrolled,
    input  logic        i_attr_we,
    input  logic [7:0]  i_attribute
);

    logic [7:0] r_attr;
    logic       w_hold;
    logic       w_cmd_valid;
    logic       w_cmd_pop;
    t_cmd       w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_attr_we) begin
            r_attr <= i_attribute;
        end
    end

    tcw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_action   (i_action),
        .i_char_code(i_char_code),
        .i_read_row (i_read_row),
        .i_read_col (i_read_col),
        .i_hold     (w_hold),
        .o_full     (full),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    tcw_back #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      (r_attr),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_hold      (w_hold),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_cell_data (o_cell_data),
        .o_cursor_col(o_cursor_col),
        .o_cursor_row(o_cursor_row),
        .o_scrolled  (o_scrolled)
    );

endmodule

// ===== sv/tcw_ram.sv =====
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tcw_front.sv =====
module tcw_front
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_action,
    input  logic [7:0] i_char_code,
    input  logic [4:0] i_read_row,
    input  logic [6:0] i_read_col,
    input  logic       i_hold,
    output logic       o_full,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_accept;
    logic       w_take;

    always_comb begin
        w_cmd.code = i_char_code;
        w_cmd.row  = i_read_row;
        w_cmd.col  = i_read_col;
        priority if (i_action) begin
            w_cmd.op = OP_READ;
        end else if (i_char_code == CH_CR) begin
            w_cmd.op = OP_CR;
        end else if (i_char_code == CH_LF) begin
            w_cmd.op = OP_LF;
        end else if (i_char_code == CH_TAB) begin
            w_cmd.op = OP_TAB;
        end else begin
            w_cmd.op = OP_PRINT;
        end
    end

    assign o_full      = (r_cnt == 2'd2) || i_hold;
    assign w_accept    = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_take      = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_accept) begin
                r_wp <= ~r_wp;
            end
            if (w_take) begin
                r_rp <= ~r_rp;
            end
            unique case ({w_accept, w_take})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/tcw_back.sv =====
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_attr,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic              o_hold,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [CELL_W-1:0] o_cell_data,
    output logic [6:0]        o_cursor_col,
    output logic [4:0]        o_cursor_row,
    output logic              o_scrolled
);

    localparam int N         = ROWS * COLS;
    localparam int AW        = $clog2(N);
    localparam int CCW       = $clog2(COLS);
    localparam int RW        = $clog2(ROWS);
    localparam int LAST_BASE = (ROWS - 1) * COLS;

    t_bstate           r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [CCW-1:0]    r_cur_col, n_cur_col;
    logic [RW-1:0]     r_cur_row, n_cur_row;
    logic [AW-1:0]     r_addr, n_addr;
    logic [CCW-1:0]    r_cnt, n_cnt;
    logic [AW:0]       r_src, n_src;
    logic [AW-1:0]     r_dst, n_dst;
    logic              r_pend, n_pend;
    logic [3:0]        r_rem, n_rem;
    logic [7:0]        r_code, n_code;
    logic [CELL_W-1:0] r_data, n_data;
    logic              r_sc, n_sc;

    logic              r_out_valid;
    logic [CELL_W-1:0] r_out_data;
    logic [6:0]        r_out_col;
    logic [4:0]        r_out_row;
    logic              r_out_sc;

    logic              w_we, w_re;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [CELL_W-1:0] w_wdata, w_rdata;

    logic [AW-1:0]     w_row_base;
    logic [AW-1:0]     w_cur_addr;
    logic [AW-1:0]     w_rd_addr;
    logic              w_rd_in_range;
    logic              w_last_row;
    logic              w_col_last;
    logic              w_src_live;
    logic              w_out_free;
    logic [CELL_W-1:0] w_blank;

    assign w_row_base    = AW'(r_cur_row) * AW'(COLS);
    assign w_cur_addr    = w_row_base + AW'(r_cur_col);
    assign w_rd_addr     = AW'(r_cmd.row) * AW'(COLS) + AW'(r_cmd.col);
    assign w_rd_in_range = (32'(r_cmd.row) < ROWS) && (32'(r_cmd.col) < COLS);
    assign w_last_row    = (r_cur_row == RW'(ROWS - 1));
    assign w_col_last    = (r_cur_col == CCW'(COLS - 1));
    assign w_src_live    = (r_src < (AW + 1)'(N));
    assign w_out_free    = !r_out_valid || i_pop;
    assign w_blank       = {i_attr, CH_SPACE};

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_src     = r_src;
        n_dst     = r_dst;
        n_pend    = r_pend;
        n_rem     = r_rem;
        n_code    = r_code;
        n_data    = r_data;
        n_sc      = r_sc;
        unique case (r_state)
            ST_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == AW'(N - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_sc = 1'b0;
                unique case (r_cmd.op)
                    OP_READ: begin
                        if (w_rd_in_range) begin
                            n_addr  = w_rd_addr;
                            n_state = ST_RD_ISSUE;
                        end else begin
                            n_data  = '0;
                            n_state = ST_DONE;
                        end
                    end
                    OP_CR: begin
                        n_addr    = w_row_base;
                        n_cnt     = '0;
                        n_cur_col = '0;
                        n_data    = w_blank;
                        n_rem     = '0;
                        n_state   = ST_BLANK;
                    end
                    OP_LF: begin
                        n_cur_col = '0;
                        n_rem     = '0;
                        if (w_last_row) begin
                            n_sc    = 1'b1;
                            n_data  = w_blank;
                            n_src   = (AW + 1)'(COLS);
                            n_pend  = 1'b0;
                            n_state = ST_SCROLL;
                        end else begin
                            n_cur_row = r_cur_row + 1'b1;
                            n_data    = '0;
                            n_state   = ST_DONE;
                        end
                    end
                    OP_TAB: begin
                        n_rem   = 4'(TAB_STOP) - {1'b0, r_cur_col[2:0]};
                        n_code  = CH_SPACE;
                        n_data  = w_blank;
                        n_state = ST_PUT;
                    end
                    OP_PRINT: begin
                        n_rem   = 4'd1;
                        n_code  = r_cmd.code;
                        n_data  = {i_attr, r_cmd.code};
                        n_state = ST_PUT;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_RD_ISSUE: begin
                n_state = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                n_data  = w_rdata;
                n_state = ST_DONE;
            end
            ST_PUT: begin
                n_rem   = r_rem - 4'd1;
                n_state = (r_rem == 4'd1) ? ST_DONE : ST_PUT;
                if (w_col_last) begin
                    n_cur_col = '0;
                    if (w_last_row) begin
                        // The blank pass after the scroll resumes the tab if spaces remain.
                        n_sc    = 1'b1;
                        n_src   = (AW + 1)'(COLS);
                        n_pend  = 1'b0;
                        n_state = ST_SCROLL;
                    end else begin
                        n_cur_row = r_cur_row + 1'b1;
                    end
                end else begin
                    n_cur_col = r_cur_col + 1'b1;
                end
            end
            ST_SCROLL: begin
                // Read one row ahead each cycle and write what came back last cycle.
                n_pend = w_src_live;
                if (w_src_live) begin
                    n_src = r_src + 1'b1;
                    n_dst = AW'(r_src - (AW + 1)'(COLS));
                end
                if (!w_src_live && !r_pend) begin
                    n_addr  = AW'(LAST_BASE);
                    n_cnt   = '0;
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CCW'(COLS - 1)) begin
                    n_state = (r_rem != 4'd0) ? ST_PUT : ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_addr;
        w_wdata   = w_blank;
        w_re      = 1'b0;
        w_raddr   = r_addr;
        o_cmd_pop = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = {ATTR_RESET, CH_SPACE};
            end
            ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            ST_RD_ISSUE: begin
                w_re = 1'b1;
            end
            ST_PUT: begin
                w_we    = 1'b1;
                w_waddr = w_cur_addr;
                w_wdata = {i_attr, r_code};
            end
            ST_SCROLL: begin
                w_re    = w_src_live;
                w_raddr = AW'(r_src);
                w_we    = r_pend;
                w_waddr = r_dst;
                w_wdata = w_rdata;
            end
            ST_BLANK: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign o_hold = (r_state == ST_CLEAR);

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(N)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_sc      <= 1'b0;
            r_rem     <= '0;
        end else begin
            r_state   <= n_state;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_addr    <= n_addr;
            r_pend    <= n_pend;
            r_sc      <= n_sc;
            r_rem     <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_cnt  <= n_cnt;
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_code <= n_code;
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_data <= r_data;
            r_out_col  <= 7'(r_cur_col);
            r_out_row  <= 5'(r_cur_row);
            r_out_sc   <= r_sc;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_cell_data  = r_out_data;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_scrolled   = r_out_sc;

endmodule

// ===== sv/tcw_chk.sv =====
module tcw_chk #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_full,
    input logic        i_empty,
    input logic        i_pop,
    input logic [15:0] i_cell_data,
    input logic [6:0]  i_cursor_col,
    input logic [4:0]  i_cursor_row,
    input logic        i_scrolled
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> i_empty)
        else $error("result queue not empty after reset");

    // The screen clearing pass holds the input side off straight after reset.
    a_reset_full: assert property (@(posedge i_clk) !i_rst_n |=> i_full)
        else $error("input accepted during screen clearing");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && !i_pop |=> !i_empty && $stable(i_cell_data)
            && $stable(i_cursor_col) && $stable(i_cursor_row) && $stable(i_scrolled))
        else $error("waiting result changed before its beat");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (COLS > 128) || (32'(i_cursor_col) < COLS))
        else $error("cursor column past the row");

    // A scroll only happens from the last row and the cursor stays there.
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && i_scrolled |-> (ROWS > 32) || (32'(i_cursor_row) == ROWS - 1))
        else $error("scrolled result not on the last row");

endmodule

bind text_console_writer_unit tcw_chk #(
    .COLS(COLS),
    .ROWS(ROWS)
) u_tcw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_full      (full),
    .i_empty     (empty),
    .i_pop       (pop),
    .i_cell_data (o_cell_data),
    .i_cursor_col(o_cursor_col),
    .i_cursor_row(o_cursor_row),
    .i_scrolled  (o_scrolled)
);
